[rtl/srm_pkg.sv]
package srm_pkg;

  localparam logic [15:0] BAND_RESET = 16'd3277;
  localparam logic [14:0] OVER_SCALE = 15'd25600;
  localparam int          OVER_BITS  = 16;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_CALC = 2'b10
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_PREP = 4'b0010,
    B_RUN  = 4'b0100,
    B_DONE = 4'b1000
  } back_state_t;

  typedef struct packed {
    logic [15:0] setpoint;
    logic [15:0] excess;
    logic        over_en;
    logic        in_band;
    logic [31:0] settle_time;
  } job_t;

endpackage

[rtl/step_response_metrics.sv]
// Channel  Direction  Handshake            Payload
// input    in         push / full          setpoint, speed, time_stamp
// result   out        pop / empty          overshoot, settled, settle_time, steady_error
// config   in         cfg_write            cfg_data (band_fraction)
//
// The front stage takes one item at a time: ring read, then window and band update;
// it waits while the queue is full. The back stage takes one item at a time too: prep,
// the bit-serial overshoot and mean dividers, then done until the result register frees.
// A two-entry queue and the result register let either side stall without loss.
// Reset is synchronous; the window ring holds no reset, and its read data is used only once the window is full.
module step_response_metrics #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [15:0]        setpoint,
  input  logic [15:0]        speed,
  input  logic [31:0]        time_stamp,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        overshoot,
  output logic               settled,
  output logic [31:0]        settle_time,
  output logic signed [24:0] steady_error
);

  localparam int PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = 16 + FW;
  localparam int JW = $bits(srm_pkg::job_t);
  localparam int QW = JW + SW + FW;

  logic          f_push;
  srm_pkg::job_t f_job;
  logic [SW-1:0] f_sum;
  logic [FW-1:0] f_fill;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic [QW-1:0] q_dout;
  srm_pkg::job_t b_job;
  logic [SW-1:0] b_sum;
  logic [FW-1:0] b_fill;

  assign b_job  = q_dout[QW-1 -: JW];
  assign b_sum  = q_dout[FW +: SW];
  assign b_fill = q_dout[FW-1:0];

  srm_front #(
    .DEPTH (WINDOW_DEPTH),
    .PW    (PW),
    .FW    (FW),
    .SW    (SW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .setpoint   (setpoint),
    .speed      (speed),
    .time_stamp (time_stamp),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .q_push     (f_push),
    .q_job      (f_job),
    .q_sum      (f_sum),
    .q_fill     (f_fill)
  );

  srm_queue #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   ({f_job, f_sum, f_fill}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  srm_back #(
    .FW (FW),
    .SW (SW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_job        (b_job),
    .q_sum        (b_sum),
    .q_fill       (b_fill),
    .empty        (empty),
    .pop          (pop),
    .overshoot    (overshoot),
    .settled      (settled),
    .settle_time  (settle_time),
    .steady_error (steady_error)
  );

endmodule

[rtl/srm_front.sv]
module srm_front #(
  parameter int DEPTH = 16,
  parameter int PW    = 4,
  parameter int FW    = 5,
  parameter int SW    = 21
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [15:0]       setpoint,
  input  logic [15:0]       speed,
  input  logic [31:0]       time_stamp,
  input  logic              cfg_write,
  input  logic [15:0]       cfg_data,
  input  logic              q_full,
  output logic              q_push,
  output srm_pkg::job_t     q_job,
  output logic [SW-1:0]     q_sum,
  output logic [FW-1:0]     q_fill
);

  srm_pkg::front_state_t state;

  logic [15:0]   band_fraction;
  logic [15:0]   last_setpoint;
  logic          setpoint_seen;
  logic [15:0]   peak_speed;
  logic [31:0]   start_time;
  logic [31:0]   last_out_time;
  logic [PW-1:0] ring_position;
  logic [FW-1:0] fill_count;
  logic [SW-1:0] ring_sum;

  logic [15:0]   sp;
  logic [15:0]   spd;
  logic [31:0]   t;
  logic          restart;
  logic [15:0]   ring [DEPTH];
  logic [15:0]   rd_data;

  logic          accept;
  logic          commit;
  logic          restart_in;
  logic [PW-1:0] rd_addr;

  logic [15:0]   peak_base;
  logic [15:0]   peak_next;
  logic [31:0]   start_next;
  logic [31:0]   out_base;
  logic [31:0]   last_out_time_next;
  logic [PW-1:0] pos_base;
  logic [PW-1:0] ring_position_next;
  logic [FW-1:0] fill_base;
  logic [FW-1:0] fill_count_next;
  logic [SW-1:0] sum_base;
  logic [SW-1:0] drop_value;
  logic [SW-1:0] ring_sum_next;
  logic [15:0]   diff;
  logic [31:0]   band_limit;
  logic          in_band;

  assign full       = (state != srm_pkg::F_IDLE);
  assign accept     = push && (state == srm_pkg::F_IDLE);
  assign commit     = (state == srm_pkg::F_CALC) && !q_full;
  assign restart_in = !setpoint_seen || (setpoint != last_setpoint);
  assign rd_addr    = restart_in ? '0 : ring_position;

  always_comb begin
    peak_base  = restart ? spd : peak_speed;
    peak_next  = (spd > peak_base) ? spd : peak_base;
    start_next = restart ? t : start_time;
    out_base   = restart ? t : last_out_time;
    pos_base   = restart ? '0 : ring_position;
    fill_base  = restart ? '0 : fill_count;
    sum_base   = restart ? '0 : ring_sum;

    diff       = (sp > spd) ? sp - spd : spd - sp;
    band_limit = 32'(band_fraction) * 32'(sp);
    in_band    = {diff, 16'h0000} <= band_limit;
    last_out_time_next = in_band ? out_base : t;

    drop_value    = (fill_base == FW'(DEPTH)) ? SW'(rd_data) : '0;
    ring_sum_next = sum_base - drop_value + SW'(spd);
    ring_position_next = (pos_base == PW'(DEPTH - 1)) ? '0 : pos_base + 1'b1;
    fill_count_next    = (fill_base < FW'(DEPTH)) ? fill_base + 1'b1 : fill_base;

    q_job.setpoint    = sp;
    q_job.excess      = peak_next - sp;
    q_job.over_en     = (sp != 16'h0000) && (peak_next > sp);
    q_job.in_band     = in_band;
    q_job.settle_time = last_out_time_next - start_next;
    q_sum             = ring_sum_next;
    q_fill            = fill_count_next;
    q_push            = commit;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= ring[rd_addr];
    end
    if (commit) begin
      ring[pos_base] <= spd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sp      <= setpoint;
      spd     <= speed;
      t       <= time_stamp;
      restart <= restart_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= srm_pkg::F_IDLE;
      band_fraction <= srm_pkg::BAND_RESET;
      last_setpoint <= '0;
      setpoint_seen <= 1'b0;
      peak_speed    <= '0;
      start_time    <= '0;
      last_out_time <= '0;
      ring_position <= '0;
      fill_count    <= '0;
      ring_sum      <= '0;
    end else begin
      if (cfg_write) begin
        band_fraction <= cfg_data;
      end
      case (state)
        srm_pkg::F_IDLE: begin
          if (accept) begin
            state <= srm_pkg::F_CALC;
          end
        end
        srm_pkg::F_CALC: begin
          if (commit) begin
            state         <= srm_pkg::F_IDLE;
            last_setpoint <= sp;
            setpoint_seen <= 1'b1;
            peak_speed    <= peak_next;
            start_time    <= start_next;
            last_out_time <= last_out_time_next;
            ring_position <= ring_position_next;
            fill_count    <= fill_count_next;
            ring_sum      <= ring_sum_next;
          end
        end
        default: begin
          state <= srm_pkg::F_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/srm_queue.sv]
module srm_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  logic [W-1:0] slot [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/srm_back.sv]
module srm_back #(
  parameter int FW = 5,
  parameter int SW = 21
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  output logic                q_pop,
  input  srm_pkg::job_t       q_job,
  input  logic [SW-1:0]       q_sum,
  input  logic [FW-1:0]       q_fill,
  output logic                empty,
  input  logic                pop,
  output logic [15:0]         overshoot,
  output logic                settled,
  output logic [31:0]         settle_time,
  output logic signed [24:0]  steady_error
);

  localparam int NM = SW + 8;
  localparam int KW = $clog2(NM);

  srm_pkg::back_state_t state;

  srm_pkg::job_t job;
  logic [FW-1:0] fill;
  logic [30:0]   num;
  logic          sat;
  logic [15:0]   rem_o;
  logic [15:0]   dvd_o;
  logic [FW-1:0] rem_m;
  logic [NM-1:0] dvd_m;
  logic [KW-1:0] k;
  logic          out_valid;

  logic [16:0]   trial_o;
  logic          ge_o;
  logic [FW:0]   trial_m;
  logic          ge_m;
  logic [15:0]   over_value;
  logic [24:0]   err_value;

  assign q_pop = (state == srm_pkg::B_IDLE) && !q_empty;
  assign empty = !out_valid;

  always_comb begin
    trial_o    = {rem_o, dvd_o[15]};
    ge_o       = trial_o >= {1'b0, job.setpoint};
    trial_m    = {rem_m, dvd_m[NM-1]};
    ge_m       = trial_m >= {1'b0, fill};
    over_value = !job.over_en ? 16'h0000 : (sat ? 16'hFFFF : dvd_o);
    err_value  = {1'b0, job.setpoint, 8'h00} - {1'b0, dvd_m[23:0]};
  end

  always_ff @(posedge clk) begin
    case (state)
      srm_pkg::B_IDLE: begin
        if (q_pop) begin
          job  <= q_job;
          fill <= q_fill;
          num  <= 31'(q_job.excess) * 31'(srm_pkg::OVER_SCALE);
          dvd_m <= {q_sum, 8'h00};
        end
      end
      srm_pkg::B_PREP: begin
        sat   <= {1'b0, num} >= {job.setpoint, 16'h0000};
        rem_o <= {1'b0, num[30:16]};
        dvd_o <= num[15:0];
        rem_m <= '0;
      end
      srm_pkg::B_RUN: begin
        if (k < KW'(srm_pkg::OVER_BITS)) begin
          rem_o <= ge_o ? 16'(trial_o - {1'b0, job.setpoint}) : trial_o[15:0];
          dvd_o <= {dvd_o[14:0], ge_o};
        end
        rem_m <= ge_m ? FW'(trial_m - {1'b0, fill}) : trial_m[FW-1:0];
        dvd_m <= {dvd_m[NM-2:0], ge_m};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if ((state == srm_pkg::B_DONE) && !out_valid) begin
      overshoot    <= over_value;
      settled      <= job.in_band;
      settle_time  <= job.settle_time;
      steady_error <= err_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= srm_pkg::B_IDLE;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        srm_pkg::B_IDLE: begin
          if (q_pop) begin
            state <= srm_pkg::B_PREP;
          end
        end
        srm_pkg::B_PREP: begin
          k     <= '0;
          state <= srm_pkg::B_RUN;
        end
        srm_pkg::B_RUN: begin
          k <= k + 1'b1;
          if (k == KW'(NM - 1)) begin
            state <= srm_pkg::B_DONE;
          end
        end
        srm_pkg::B_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            state     <= srm_pkg::B_IDLE;
          end
        end
        default: begin
          state <= srm_pkg::B_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/srm_checker.sv]
module srm_checker (
  input logic              clk,
  input logic              rst,
  input logic              push,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input logic [15:0]       overshoot,
  input logic              settled,
  input logic [31:0]       settle_time,
  input logic signed [24:0] steady_error
);

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not cleared after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("input taken again before item was processed");

  a_pop_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty) |=> empty)
    else $error("result still shown after it was taken");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty && $stable(overshoot) && $stable(settled)
      && $stable(settle_time) && $stable(steady_error))
    else $error("stalled result changed");

endmodule

bind step_response_metrics srm_checker u_srm_checker (
  .clk          (clk),
  .rst          (rst),
  .push         (push),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .overshoot    (overshoot),
  .settled      (settled),
  .settle_time  (settle_time),
  .steady_error (steady_error)
);
